@@ src/atcp_pkg.sv @@
// Shared types and constants for the ANSI text console parser.
// No dependencies; imported by atcp_core and ansi_text_console_parser.
package atcp_pkg;

  // Parse mode of the escape sequence decoder
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_NUMBER = 2'd2
  } mode_e;

  // Result command codes
  localparam logic CMD_DRAW  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_GLYPH_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_GLYPH_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd2;

  localparam int unsigned CoordW = 12;
  localparam logic [CoordW-1:0] COORD_MAX = 12'hFFF;

  // Palette (ARGB)
  localparam logic [31:0] COL_BLACK  = 32'hFF202020;
  localparam logic [31:0] COL_RED    = 32'hFFDE382B;
  localparam logic [31:0] COL_GREEN  = 32'hFF00A600;
  localparam logic [31:0] COL_YELLOW = 32'hFFFFC706;
  localparam logic [31:0] COL_CYAN   = 32'hFF2CB5E9;
  localparam logic [31:0] COL_WHITE  = 32'hFFF2EFDE;
  localparam logic [31:0] COL_GREY   = 32'hFF808080;

  // Select Graphic Rendition parameters with a defined effect
  localparam logic [7:0] SGR_RESET     = 8'd0;
  localparam logic [7:0] SGR_FG_RED    = 8'd31;
  localparam logic [7:0] SGR_FG_GREEN  = 8'd32;
  localparam logic [7:0] SGR_FG_YELLOW = 8'd33;
  localparam logic [7:0] SGR_FG_CYAN   = 8'd36;
  localparam logic [7:0] SGR_BG_RED    = 8'd41;
  localparam logic [7:0] SGR_BG_YELLOW = 8'd43;
  localparam logic [7:0] SGR_FG_GREY   = 8'd90;

  // Character codes
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ESC   = 8'h1B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_CLEAR = 8'h4A;  // 'J'
  localparam logic [7:0] CHAR_SGR   = 8'h6D;  // 'm'

  // Configuration as seen by the step logic
  typedef struct packed {
    logic [4:0]        glyph_width;
    logic [5:0]        glyph_height;
    logic [CoordW-1:0] screen_height;
  } cfg_t;

  // Parser and cursor state
  typedef struct packed {
    mode_e             mode;
    logic [7:0]        param;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [31:0]       fg;
    logic [31:0]       bg;
  } state_t;

  // One result word
  typedef struct packed {
    logic              cmd;
    logic [7:0]        glyph;
    logic [CoordW-1:0] draw_x;
    logic [CoordW-1:0] draw_y;
    logic [31:0]       glyph_fg;
    logic [31:0]       glyph_bg;
    logic [CoordW-1:0] flush_first_row;
    logic [CoordW-1:0] flush_row_count;
  } result_t;

endpackage

@@ src/atcp_core.sv @@
// Next-state and result logic for one character of the console parser.
// Depends on atcp_pkg.
module atcp_core
  import atcp_pkg::*;
(
  input  logic [7:0] char_i,
  input  cfg_t       cfg_i,
  input  state_t     state_i,
  output state_t     state_o,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic        digit;
  logic [7:0]  digit_val;
  logic [12:0] col_sum;
  logic [12:0] row_sum;

  assign digit     = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
  assign digit_val = char_i - CHAR_ZERO;
  assign col_sum   = {1'b0, state_i.col} + {8'd0, cfg_i.glyph_width};
  assign row_sum   = {1'b0, state_i.row} + {7'd0, cfg_i.glyph_height};

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (state_i.mode)
      MODE_ESCAPE: begin
        if (digit) begin
          state_o.param = digit_val;
          state_o.mode  = MODE_NUMBER;
        end
      end
      MODE_NUMBER: begin
        if (digit) begin
          // param * 10 + digit, wrapping at 8 bits
          state_o.param = {state_i.param[4:0], 3'b000} + {state_i.param[6:0], 1'b0}
                          + digit_val;
        end else if (char_i == CHAR_SEMI) begin
          state_o.mode = MODE_ESCAPE;
        end else begin
          state_o.mode = MODE_NORMAL;
          if (char_i == CHAR_SGR) begin
            case (state_i.param)
              SGR_RESET: begin
                state_o.fg = COL_WHITE;
                state_o.bg = COL_BLACK;
              end
              SGR_FG_RED:    state_o.fg = COL_RED;
              SGR_FG_GREEN:  state_o.fg = COL_GREEN;
              SGR_FG_YELLOW: state_o.fg = COL_YELLOW;
              SGR_FG_CYAN:   state_o.fg = COL_CYAN;
              SGR_BG_RED:    state_o.bg = COL_RED;
              SGR_BG_YELLOW: state_o.bg = COL_YELLOW;
              SGR_FG_GREY:   state_o.fg = COL_GREY;
              default: ;
            endcase
          end else if (char_i == CHAR_CLEAR) begin
            state_o.row             = '0;
            res_valid_o             = 1'b1;
            res_o.cmd               = CMD_CLEAR;
            res_o.glyph_fg          = COL_BLACK;
            res_o.flush_row_count   = cfg_i.screen_height;
          end
        end
      end
      default: begin
        // normal text, and the spare mode code
        state_o.mode = MODE_NORMAL;
        case (char_i)
          CHAR_BS: begin
            if (state_i.col >= {7'd0, cfg_i.glyph_width}) begin
              state_o.col = state_i.col - {7'd0, cfg_i.glyph_width};
            end
          end
          CHAR_LF: begin
            state_o.col = '0;
            state_o.row = row_sum[12] ? COORD_MAX : row_sum[11:0];
          end
          CHAR_ESC: state_o.mode = MODE_ESCAPE;
          default: begin
            res_valid_o           = 1'b1;
            res_o.cmd             = CMD_DRAW;
            res_o.glyph           = char_i;
            res_o.draw_x          = state_i.col;
            res_o.draw_y          = state_i.row;
            res_o.glyph_fg        = state_i.fg;
            res_o.glyph_bg        = state_i.bg;
            res_o.flush_first_row = state_i.row;
            res_o.flush_row_count = {6'd0, cfg_i.glyph_height};
            state_o.col           = col_sum[12] ? COORD_MAX : col_sum[11:0];
          end
        endcase
      end
    endcase
  end

endmodule

@@ src/ansi_text_console_parser.sv @@
// ANSI text console parser: each input word is held in the input register and its
// result word in the result register; throughput one word per cycle while the
// output side is ready. The rate is set by the combinational step logic between
// the two registers; the parser state updates once per word.
// rst_ni (asynchronous, active low) returns to normal text mode, cursor 0,0,
// default colours and default glyph and screen sizes.
module ansi_text_console_parser
  import atcp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [11:0]  cfg_data_i,
  // input stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] char_code
  // output stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [7:0] glyph, [19:8] draw_x, [31:20] draw_y, [63:32] glyph_fg,
  // [95:64] glyph_bg, [107:96] flush_first_row, [119:108] flush_row_count
  output logic [119:0] m_axis_tdata_o,
  output logic         m_axis_tuser_o    // [0] cmd
);

  // Input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_char_q;

  // Configuration registers
  cfg_t cfg_q;

  // Parser state
  state_t state_q, state_d;

  // Result register
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  logic    step_res_valid;
  result_t step_res;
  logic    advance;
  logic    in_take;

  // Advance the held word when the result slot is free or being drained.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  atcp_core u_core (
    .char_i      (in_char_q),
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .res_valid_o (step_res_valid),
    .res_o       (step_res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = step_res_valid;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Input word register; payload needs no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= s_axis_tdata_i;
    end
  end

  // Configuration: writes beyond the register list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_width   <= 5'd8;
      cfg_q.glyph_height  <= 6'd16;
      cfg_q.screen_height <= 12'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GLYPH_WIDTH:   cfg_q.glyph_width   <= cfg_data_i[4:0];
        CFG_GLYPH_HEIGHT:  cfg_q.glyph_height  <= cfg_data_i[5:0];
        CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parser state: update once per word consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode  <= MODE_NORMAL;
      state_q.param <= '0;
      state_q.col   <= '0;
      state_q.row   <= '0;
      state_q.fg    <= COL_WHITE;
      state_q.bg    <= COL_BLACK;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step_res_valid) begin
      out_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.cmd;
  assign m_axis_tdata_o  = {out_q.flush_row_count, out_q.flush_first_row,
                            out_q.glyph_bg, out_q.glyph_fg,
                            out_q.draw_y, out_q.draw_x, out_q.glyph};

endmodule

@@ tb/tb_ansi_text_console_parser.sv @@
// Self-checking testbench for the ANSI text console parser stream block.
// Depends on atcp_pkg and ansi_text_console_parser; predicts every draw and
// clear word from a behavioural copy of the parser state.
`timescale 1ns / 100ps

module tb_ansi_text_console_parser
  import atcp_pkg::*;
;

  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WatchdogLimit = 2000;  // well above the longest hold-off
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned MaxReported   = 40;

  // Index past the end of the register list; writes to it must be dropped
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_STREAM   = 2'd0,
    RX_RANDOM   = 2'd1,
    RX_PERIODIC = 2'd2
  } rx_pattern_e;

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic         clk_i      = 1'b0;
  logic         rst_ni     = 1'b0;
  logic         cfg_we     = 1'b0;
  logic [1:0]   cfg_idx    = '0;
  logic [11:0]  cfg_data   = '0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic         out_tuser;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  ansi_text_console_parser uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (in_tvalid),
    .s_axis_tready_o (in_tready),
    .s_axis_tdata_i  (in_tdata),
    .m_axis_tvalid_o (out_tvalid),
    .m_axis_tready_i (out_tready),
    .m_axis_tdata_o  (out_tdata),
    .m_axis_tuser_o  (out_tuser)
  );

  // ---------------------------------------------------------------------------
  // Console state as predicted by the testbench
  // ---------------------------------------------------------------------------
  logic [4:0]  glyph_w;
  logic [5:0]  glyph_h;
  logic [11:0] screen_rows;
  mode_e       parse_mode;
  logic [7:0]  sgr_param;
  logic [11:0] cursor_col;
  logic [11:0] cursor_row;
  logic [31:0] fore_colour;
  logic [31:0] back_colour;

  result_t pending_cmds[$];  // draw/clear words still owed by the block
  int      mismatch_count = 0;
  int      chars_sent     = 0;

  // Sender burst control
  bit      gaps_enabled = 1'b1;
  int      burst_left   = 0;

  // Receiver control; hold_off_left is raised by a test and counted down here
  int          hold_off_left   = 0;
  rx_pattern_e rx_pattern      = RX_STREAM;
  int          rx_pattern_left = 0;
  int unsigned rx_tick         = 0;

  int      idle_cycles = 0;
  result_t seen_word;
  result_t owed_word;

  function automatic logic [11:0] sat_coord(input logic [11:0] base, input logic [5:0] step);
    logic [12:0] sum;
    sum = {1'b0, base} + {7'd0, step};
    return (sum > {1'b0, COORD_MAX}) ? COORD_MAX : sum[11:0];
  endfunction

  task automatic reset_console_model();
    glyph_w     = 5'd8;
    glyph_h     = 6'd16;
    screen_rows = 12'd480;
    parse_mode  = MODE_NORMAL;
    sgr_param   = '0;
    cursor_col  = '0;
    cursor_row  = '0;
    fore_colour = COL_WHITE;
    back_colour = COL_BLACK;
  endtask

  // Apply the collected parameter from the colour table; unlisted values do nothing
  task automatic apply_sgr_param();
    case (sgr_param)
      SGR_RESET: begin
        fore_colour = COL_WHITE;
        back_colour = COL_BLACK;
      end
      SGR_FG_RED:    fore_colour = COL_RED;
      SGR_FG_GREEN:  fore_colour = COL_GREEN;
      SGR_FG_YELLOW: fore_colour = COL_YELLOW;
      SGR_FG_CYAN:   fore_colour = COL_CYAN;
      SGR_BG_RED:    back_colour = COL_RED;
      SGR_BG_YELLOW: back_colour = COL_YELLOW;
      SGR_FG_GREY:   fore_colour = COL_GREY;
      default: ;
    endcase
  endtask

  // Advance the predicted state by one accepted character; queue any word it owes
  task automatic interpret_char(input logic [7:0] code);
    result_t word;
    logic    is_digit;
    word     = '0;
    is_digit = (code >= CHAR_ZERO) && (code <= CHAR_NINE);
    case (parse_mode)
      MODE_ESCAPE: begin
        // non-digits are swallowed and the escape stays open
        if (is_digit) begin
          sgr_param  = code - CHAR_ZERO;
          parse_mode = MODE_NUMBER;
        end
      end
      MODE_NUMBER: begin
        if (is_digit) begin
          sgr_param = sgr_param * 8'd10 + (code - CHAR_ZERO);  // wraps at 256
        end else if (code == CHAR_SEMI) begin
          parse_mode = MODE_ESCAPE;
        end else begin
          parse_mode = MODE_NORMAL;
          if (code == CHAR_SGR) begin
            apply_sgr_param();
          end else if (code == CHAR_CLEAR) begin
            // whole-screen clear: row homes, column is left alone
            cursor_row           = '0;
            word.cmd             = CMD_CLEAR;
            word.glyph_fg        = COL_BLACK;
            word.flush_row_count = screen_rows;
            pending_cmds.push_back(word);
          end
        end
      end
      default: begin
        parse_mode = MODE_NORMAL;
        if (code == CHAR_BS) begin
          if (cursor_col >= {7'd0, glyph_w}) cursor_col = cursor_col - {7'd0, glyph_w};
        end else if (code == CHAR_LF) begin
          cursor_col = '0;
          cursor_row = sat_coord(cursor_row, glyph_h);
        end else if (code == CHAR_ESC) begin
          parse_mode = MODE_ESCAPE;
        end else begin
          word.cmd             = CMD_DRAW;
          word.glyph           = code;
          word.draw_x          = cursor_col;
          word.draw_y          = cursor_row;
          word.glyph_fg        = fore_colour;
          word.glyph_bg        = back_colour;
          word.flush_first_row = cursor_row;
          word.flush_row_count = {6'd0, glyph_h};
          pending_cmds.push_back(word);
          cursor_col = sat_coord(cursor_col, {1'b0, glyph_w});
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one character word; open a random gap first when a burst runs out.
  // Valid stays high after acceptance so back-to-back words go out every cycle while the block is ready.
  task automatic send_char(input logic [7:0] code);
    int gap = 0;
    if (gaps_enabled) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, 5);
      end
      burst_left--;
    end
    if (gap > 0) begin
      @(negedge clk_i);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    do @(posedge clk_i); while (!in_tready);
    chars_sent++;
    interpret_char(code);
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_char(text[i]);
  endtask

  // Send a decimal number as at most three digit characters
  task automatic send_number(input int value);
    if (value >= 100) send_char(CHAR_ZERO + 8'((value / 100) % 10));
    if (value >= 10) send_char(CHAR_ZERO + 8'((value / 10) % 10));
    send_char(CHAR_ZERO + 8'(value % 10));
  endtask

  function automatic logic [7:0] random_printable();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // Mostly parameters from the colour table, some arbitrary ones that may wrap
  function automatic int pick_sgr_param();
    case ($urandom_range(0, 9))
      0: return int'(SGR_RESET);
      1: return int'(SGR_FG_RED);
      2: return int'(SGR_FG_GREEN);
      3: return int'(SGR_FG_YELLOW);
      4: return int'(SGR_FG_CYAN);
      5: return int'(SGR_BG_RED);
      6: return int'(SGR_BG_YELLOW);
      7: return int'(SGR_FG_GREY);
      default: return int'($urandom_range(0, 999));
    endcase
  endfunction

  // ESC, one to three parameters, then a final character; now and then the
  // sequence carries noise after ESC or is left open
  task automatic send_escape_sequence();
    int params;
    int pick;
    send_char(CHAR_ESC);
    if ($urandom_range(0, 9) == 0) send_char(8'($urandom_range(8'h3A, 8'h7E)));
    params = $urandom_range(1, 3);
    for (int i = 0; i < params; i++) begin
      send_number(pick_sgr_param());
      if (i < params - 1) send_char(CHAR_SEMI);
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) send_char(CHAR_SGR);
    else if (pick < 80) send_char(CHAR_CLEAR);
    else if (pick < 90) send_char(random_printable());
  endtask

  // Random console traffic: text, cursor controls, escape sequences and raw bytes
  task automatic feed_random_text(input int count);
    int target;
    int pick;
    target = chars_sent + count;
    while (chars_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) send_char(random_printable());
      else if (pick < 55) send_char(CHAR_LF);
      else if (pick < 63) send_char(CHAR_BS);
      else if (pick < 88) send_escape_sequence();
      else send_char(8'($urandom_range(0, 255)));
    end
  endtask

  // Drop valid, wait for every owed word, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk_i);
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write; only called with the block idle
  task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_GLYPH_WIDTH:   glyph_w     = value[4:0];
      CFG_GLYPH_HEIGHT:  glyph_h     = value[5:0];
      CFG_SCREEN_HEIGHT: screen_rows = value;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Byte extremes, cursor controls, red foreground and background, wrap, clear and
  // sequence endings, all at the reset sizes
  task automatic test_directed_sequences();
    send_char(CHAR_BS);        // backspace at the left edge: no move
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CHAR_BS);
    send_char(CHAR_LF);
    send_char(CHAR_ESC);
    send_text("m31;41m");      // 'm' straight after ESC is swallowed
    send_text("A");
    send_char(CHAR_ESC);
    send_text("287m");         // wraps to the red foreground code
    send_char(CHAR_ESC);
    send_text("0J");
    send_char(CHAR_ESC);
    send_text("5q");           // unknown final: sequence ends, nothing else
    send_text("C");
    drain_results();
  endtask

  task automatic test_default_random();
    feed_random_text(60);
    drain_results();
  endtask

  // Largest cells: run the column and then the row into saturation
  task automatic test_cursor_limits();
    write_reg(CFG_GLYPH_WIDTH, 12'hFFF);    // upper bits dropped, width 31
    write_reg(CFG_GLYPH_HEIGHT, 12'h03F);
    write_reg(CFG_SCREEN_HEIGHT, 12'hFFF);
    send_char(CHAR_LF);
    for (int i = 0; i < 140; i++) send_char(random_printable());
    send_char(CHAR_BS);
    send_char(random_printable());
    for (int i = 0; i < 70; i++) begin
      send_char(CHAR_LF);
      if (i % 7 == 0) send_char(random_printable());
    end
    send_char(CHAR_ESC);
    send_number(2);
    send_char(CHAR_CLEAR);
    drain_results();
  endtask

  // Zero sizes step by nothing and flush nothing; the spare index is ignored
  task automatic test_zero_sizes();
    write_reg(CFG_GLYPH_WIDTH, 12'hFE0);
    write_reg(CFG_GLYPH_HEIGHT, 12'hFC0);
    write_reg(CFG_SCREEN_HEIGHT, 12'h000);
    write_reg(CFG_UNUSED_IDX, 12'hABC);
    feed_random_text(30);
    drain_results();
  endtask

  // Smallest legal sizes, sender streaming without gaps
  task automatic test_minimum_sizes();
    write_reg(CFG_GLYPH_WIDTH, 12'h001);
    write_reg(CFG_GLYPH_HEIGHT, 12'h001);
    write_reg(CFG_SCREEN_HEIGHT, 12'h001);
    gaps_enabled = 1'b0;
    feed_random_text(50);
    gaps_enabled = 1'b1;
    drain_results();
  endtask

  // Hold the receiver off while text keeps coming, so the block backs up
  task automatic test_output_backpressure();
    hold_off_left = HoldOffCycles;
    gaps_enabled  = 1'b0;
    for (int i = 0; i < 40; i++) send_char(random_printable());
    gaps_enabled  = 1'b1;
    drain_results();
  endtask

  task automatic test_random_config();
    write_reg(CFG_GLYPH_WIDTH, 12'($urandom_range(1, 16)));
    write_reg(CFG_GLYPH_HEIGHT, 12'($urandom_range(1, 32)));
    write_reg(CFG_SCREEN_HEIGHT, 12'($urandom_range(1, 4095)));
    feed_random_text(60);
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: switch between stall patterns; honour a requested hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    rx_tick++;
    if (hold_off_left > 0) begin
      out_tready <= 1'b0;
      hold_off_left--;
    end else begin
      if (rx_pattern_left == 0) begin
        rx_pattern      = rx_pattern_e'($urandom_range(0, 2));
        rx_pattern_left = $urandom_range(20, 80);
      end
      rx_pattern_left--;
      case (rx_pattern)
        RX_STREAM:   out_tready <= 1'b1;
        RX_RANDOM:   out_tready <= 1'($urandom_range(0, 1));
        default:     out_tready <= (rx_tick % 4) != 0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking: compare each accepted word with the oldest owed one
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MaxReported)
      $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (out_tvalid && out_tready) begin
      seen_word.cmd             = out_tuser;
      seen_word.glyph           = out_tdata[7:0];
      seen_word.draw_x          = out_tdata[19:8];
      seen_word.draw_y          = out_tdata[31:20];
      seen_word.glyph_fg        = out_tdata[63:32];
      seen_word.glyph_bg        = out_tdata[95:64];
      seen_word.flush_first_row = out_tdata[107:96];
      seen_word.flush_row_count = out_tdata[119:108];
      if (pending_cmds.size() == 0) begin
        report_mismatch("word with nothing owed", out_tdata[31:0], '0);
      end else begin
        owed_word = pending_cmds.pop_front();
        if (seen_word.cmd != owed_word.cmd)
          report_mismatch("cmd", 32'(seen_word.cmd), 32'(owed_word.cmd));
        if (seen_word.glyph != owed_word.glyph)
          report_mismatch("glyph", 32'(seen_word.glyph), 32'(owed_word.glyph));
        if (seen_word.draw_x != owed_word.draw_x)
          report_mismatch("draw_x", 32'(seen_word.draw_x), 32'(owed_word.draw_x));
        if (seen_word.draw_y != owed_word.draw_y)
          report_mismatch("draw_y", 32'(seen_word.draw_y), 32'(owed_word.draw_y));
        if (seen_word.glyph_fg != owed_word.glyph_fg)
          report_mismatch("glyph_fg", seen_word.glyph_fg, owed_word.glyph_fg);
        if (seen_word.glyph_bg != owed_word.glyph_bg)
          report_mismatch("glyph_bg", seen_word.glyph_bg, owed_word.glyph_bg);
        if (seen_word.flush_first_row != owed_word.flush_first_row)
          report_mismatch("flush_first_row", 32'(seen_word.flush_first_row),
                          32'(owed_word.flush_first_row));
        if (seen_word.flush_row_count != owed_word.flush_row_count)
          report_mismatch("flush_row_count", 32'(seen_word.flush_row_count),
                          32'(owed_word.flush_row_count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if neither side moves a word for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no word moved for %0d cycles, %0d still owed",
                 idle_cycles, pending_cmds.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_console_model();
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_sequences();
    test_default_random();
    test_cursor_limits();
    test_zero_sizes();
    test_minimum_sizes();
    test_output_backpressure();
    test_random_config();

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ ansi_text_console_parser.f @@
src/atcp_pkg.sv
src/atcp_core.sv
src/ansi_text_console_parser.sv
tb/tb_ansi_text_console_parser.sv
